// File: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the segment intersection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SSI_ASSERT(label, clock, reset_n, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error("assertion failed");
`define SSI_ASSERT_NEVER(label, clock, reset_n, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SSI_ASSERT(label, clock, reset_n, prop)
`define SSI_ASSERT_NEVER(label, clock, reset_n, cond)
`endif
`endif

// File: rtl/ssi_pkg.sv
// Package with the types, sizes and helper functions of the segment intersection block.
`default_nettype none
package ssi_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;
    localparam int EPS_BITS   = 32;
    localparam int D_W        = 2 * COORD_BITS + 3;
    localparam int N_W        = COORD_BITS + D_W + 2;
    localparam int S_W        = N_W + FRAC_BITS;
    localparam int Q_W        = COORD_BITS + FRAC_BITS;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;
    localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } request_t;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] point_x;
        logic signed [OUT_BITS-1:0] point_y;
    } result_t;

    function automatic logic [OUT_BITS-1:0] sat_point(input logic neg,
                                                      input logic [Q_W-1:0] mag);
        logic [63:0] m;
        logic [63:0] r;
        m = 64'(mag);
        if (neg)
        begin
            if (m >= 64'h8000_0000)
                r = 64'h8000_0000;
            else
                r = 64'd0 - m;
        end
        else
        begin
            if (m > 64'h7FFF_FFFF)
                r = 64'h7FFF_FFFF;
            else
                r = m;
        end
        return r[OUT_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/ssi_div.sv
// Pipelined restoring divider, several quotient bits per stage, one item per cycle.
`default_nettype none
module ssi_div
    import ssi_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [S_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic                out_valid,
    output logic [Q_W-1:0]      quot
);
    logic [D_W-1:0] rem_reg  [DIV_STAGES];
    logic [D_W-1:0] rem_next [DIV_STAGES];
    logic [Q_W-1:0] low_reg  [DIV_STAGES];
    logic [Q_W-1:0] low_next [DIV_STAGES];
    logic [Q_W-1:0] q_reg    [DIV_STAGES];
    logic [Q_W-1:0] q_next   [DIV_STAGES];
    logic [D_W-1:0] den_reg  [DIV_STAGES];
    logic [D_W-1:0] den_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    always_comb
    begin
        logic [D_W-1:0] r;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] q;
        logic [D_W-1:0] dd;
        logic [D_W:0]   t;
        int             g;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r  = num[Q_W +: D_W];
                lo = num[Q_W-1:0];
                q  = '0;
                dd = den;
            end
            else
            begin
                r  = rem_reg[k-1];
                lo = low_reg[k-1];
                q  = q_reg[k-1];
                dd = den_reg[k-1];
            end
            for (int j = 0; j < DIV_STEP; j++)
            begin
                g = k * DIV_STEP + j;
                if (g < Q_W)
                begin
                    t = {r, lo[Q_W-1-g]};
                    if (t >= {1'b0, dd})
                    begin
                        t = t - {1'b0, dd};
                        q[Q_W-1-g] = 1'b1;
                    end
                    r = t[D_W-1:0];
                end
            end
            rem_next[k] = r;
            low_next[k] = lo;
            q_next[k]   = q;
            den_next[k] = dd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_next[k];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

// File: rtl/segment_segment_intersection.sv
// Segment intersection test: an item is accepted on every cycle that start is high.
// The result strobe follows the accepting edge through five arithmetic stages,
// eight divider stages at default sizes and the output register.
// Throughput is one item per cycle; busy stays low and the receiver cannot stall.
// Reset clears the valid bits and sets the parallel epsilon eps_reg to one.
`default_nettype none
module segment_segment_intersection
    import ssi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire request_t            request,
    output logic                     result_valid,
    output result_t                  result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [EPS_BITS-1:0] cfg_data
);
    localparam int C1_W     = COORD_BITS + 1;
    localparam int P_W      = 2 * C1_W;
    localparam int AD_W     = COORD_BITS + D_W;
    localparam int US_W     = C1_W + D_W;
    localparam int LATENCY  = 6 + DIV_STAGES;

    typedef struct packed {
        logic   hit;
        logic   same;
        logic   neg_x;
        logic   neg_y;
        coord_t ax;
        coord_t ay;
    } side_t;

    logic [EPS_BITS-1:0] eps_reg;

    // Stage 1: difference vectors.
    logic                   v1_reg;
    logic                   same1_reg;
    coord_t                 ax1_reg, ay1_reg;
    logic signed [C1_W-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg, wx1_reg, wy1_reg;

    // Stage 2: cross products.
    logic                   v2_reg;
    logic                   same2_reg;
    coord_t                 ax2_reg, ay2_reg;
    logic signed [C1_W-1:0] ux2_reg, uy2_reg;
    logic signed [P_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    // Stage 3: normalised determinant and numerators.
    logic                   v3_reg;
    logic                   same3_reg;
    coord_t                 ax3_reg, ay3_reg;
    logic signed [C1_W-1:0] ux3_reg, uy3_reg;
    logic signed [D_W-1:0]  d3_reg, sn3_reg, tn3_reg;
    logic signed [D_W-1:0]  d3_next, sn3_next, tn3_next;

    // Stage 4: hit decision and point products.
    logic                   v4_reg;
    logic                   same4_reg, hit4_reg, hit4_next;
    coord_t                 ax4_reg, ay4_reg;
    logic signed [D_W-1:0]  d4_reg;
    logic signed [AD_W-1:0] adx4_reg, ady4_reg;
    logic signed [US_W-1:0] usx4_reg, usy4_reg;

    // Stage 5: numerator magnitudes for the divider.
    logic                   v5_reg;
    side_t                  side5_reg, side5_next;
    logic [S_W-1:0]         numx5_reg, numy5_reg, numx5_next, numy5_next;
    logic [D_W-1:0]         den5_reg;

    side_t                  side_reg [DIV_STAGES];
    logic                   divx_valid, divy_valid;
    logic [Q_W-1:0]         qx, qy;
    side_t                  side_out;

    logic                   result_valid_reg;
    result_t                result_reg, result_next;
    logic                   miss_with_point;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_valid && cfg_ready)
            eps_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg           <= start && !busy;
            v2_reg           <= v1_reg;
            v3_reg           <= v2_reg;
            v4_reg           <= v3_reg;
            v5_reg           <= v4_reg;
            result_valid_reg <= divx_valid && divy_valid;
        end
    end

    always_comb
    begin
        logic signed [D_W-1:0] d, sn, tn;
        d  = D_W'(p0_reg) - D_W'(p1_reg);
        sn = D_W'(p2_reg) - D_W'(p3_reg);
        tn = D_W'(p4_reg) - D_W'(p5_reg);
        if (d < 0)
        begin
            d3_next  = -d;
            sn3_next = -sn;
            tn3_next = -tn;
        end
        else
        begin
            d3_next  = d;
            sn3_next = sn;
            tn3_next = tn;
        end
    end

    always_comb
    begin
        logic par, inside_range;
        par = (d3_reg == '0) || (64'($unsigned(d3_reg)) < 64'(eps_reg));
        inside_range = !sn3_reg[D_W-1] && (sn3_reg <= d3_reg)
                    && !tn3_reg[D_W-1] && (tn3_reg <= d3_reg);
        hit4_next = !par && inside_range;
    end

    always_comb
    begin
        logic signed [N_W-1:0] nx, ny;
        logic        [N_W-1:0] mx, my;
        nx = N_W'(adx4_reg) + N_W'(usx4_reg);
        ny = N_W'(ady4_reg) + N_W'(usy4_reg);
        mx = nx[N_W-1] ? N_W'(-nx) : N_W'(nx);
        my = ny[N_W-1] ? N_W'(-ny) : N_W'(ny);
        numx5_next = {mx, {FRAC_BITS{1'b0}}};
        numy5_next = {my, {FRAC_BITS{1'b0}}};
        side5_next.hit   = hit4_reg;
        side5_next.same  = same4_reg;
        side5_next.neg_x = nx[N_W-1];
        side5_next.neg_y = ny[N_W-1];
        side5_next.ax    = ax4_reg;
        side5_next.ay    = ay4_reg;
    end

    always_ff @(posedge clk)
    begin
        same1_reg <= (request.a_start_x == request.b_start_x)
                  && (request.a_start_y == request.b_start_y);
        ax1_reg   <= request.a_start_x;
        ay1_reg   <= request.a_start_y;
        ux1_reg   <= C1_W'(request.a_end_x) - C1_W'(request.a_start_x);
        uy1_reg   <= C1_W'(request.a_end_y) - C1_W'(request.a_start_y);
        vx1_reg   <= C1_W'(request.b_end_x) - C1_W'(request.b_start_x);
        vy1_reg   <= C1_W'(request.b_end_y) - C1_W'(request.b_start_y);
        wx1_reg   <= C1_W'(request.a_start_x) - C1_W'(request.b_start_x);
        wy1_reg   <= C1_W'(request.a_start_y) - C1_W'(request.b_start_y);

        same2_reg <= same1_reg;
        ax2_reg   <= ax1_reg;
        ay2_reg   <= ay1_reg;
        ux2_reg   <= ux1_reg;
        uy2_reg   <= uy1_reg;
        p0_reg    <= ux1_reg * vy1_reg;
        p1_reg    <= uy1_reg * vx1_reg;
        p2_reg    <= vx1_reg * wy1_reg;
        p3_reg    <= vy1_reg * wx1_reg;
        p4_reg    <= ux1_reg * wy1_reg;
        p5_reg    <= uy1_reg * wx1_reg;

        same3_reg <= same2_reg;
        ax3_reg   <= ax2_reg;
        ay3_reg   <= ay2_reg;
        ux3_reg   <= ux2_reg;
        uy3_reg   <= uy2_reg;
        d3_reg    <= d3_next;
        sn3_reg   <= sn3_next;
        tn3_reg   <= tn3_next;

        same4_reg <= same3_reg;
        hit4_reg  <= hit4_next;
        ax4_reg   <= ax3_reg;
        ay4_reg   <= ay3_reg;
        d4_reg    <= d3_reg;
        adx4_reg  <= ax3_reg * d3_reg;
        ady4_reg  <= ay3_reg * d3_reg;
        usx4_reg  <= ux3_reg * sn3_reg;
        usy4_reg  <= uy3_reg * sn3_reg;

        side5_reg <= side5_next;
        numx5_reg <= numx5_next;
        numy5_reg <= numy5_next;
        den5_reg  <= $unsigned(d4_reg);

        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
                side_reg[k] <= side5_reg;
            else
                side_reg[k] <= side_reg[k-1];
        end

        result_reg <= result_next;
    end

    ssi_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (numx5_reg),
        .den       (den5_reg),
        .out_valid (divx_valid),
        .quot      (qx)
    );

    ssi_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (numy5_reg),
        .den       (den5_reg),
        .out_valid (divy_valid),
        .quot      (qy)
    );

    assign side_out = side_reg[DIV_STAGES-1];

    always_comb
    begin
        logic [C1_W-1:0] abs_x, abs_y;
        abs_x = side_out.ax[COORD_BITS-1] ? C1_W'(-C1_W'(side_out.ax)) : C1_W'(side_out.ax);
        abs_y = side_out.ay[COORD_BITS-1] ? C1_W'(-C1_W'(side_out.ay)) : C1_W'(side_out.ay);
        result_next = '0;
        if (side_out.same)
        begin
            result_next.hit     = 1'b1;
            result_next.point_x = sat_point(side_out.ax[COORD_BITS-1],
                                            Q_W'(abs_x) << FRAC_BITS);
            result_next.point_y = sat_point(side_out.ay[COORD_BITS-1],
                                            Q_W'(abs_y) << FRAC_BITS);
        end
        else if (side_out.hit)
        begin
            result_next.hit     = 1'b1;
            result_next.point_x = sat_point(side_out.neg_x, qx);
            result_next.point_y = sat_point(side_out.neg_y, qy);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign miss_with_point = !result.hit && (result.point_x != 0 || result.point_y != 0);

`include "assert_macros.svh"

    `SSI_ASSERT(a_latency, clk, rst_n, start && !busy |-> ##LATENCY result_valid)
    `SSI_ASSERT(a_no_orphan, clk, rst_n, result_valid |-> $past(start, LATENCY))
    `SSI_ASSERT_NEVER(a_miss_zero, clk, rst_n, result_valid && miss_with_point)
endmodule
`default_nettype wire
